@@ rtl/core/max_heap_priority_queue_macros.svh @@
// Assertion macros for the priority queue RTL.
`ifndef MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define MHPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("Priority queue check failed in the same cycle.");
`define MHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("Priority queue check failed in the next cycle.");
`else
`define MHPQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/mhpq_pkg.sv @@
// Types and codes shared by the priority queue modules.
`timescale 1ns / 1ps
package mhpq_pkg;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  localparam logic [2:0] STATUS_INSERTED = 3'd0;
  localparam logic [2:0] STATUS_UPDATED  = 3'd1;
  localparam logic [2:0] STATUS_FULL     = 3'd2;
  localparam logic [2:0] STATUS_REMOVED  = 3'd3;
  localparam logic [2:0] STATUS_EMPTY    = 3'd4;

  typedef struct packed {
    logic               action;
    logic signed [31:0] key;
    logic        [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic signed [31:0] key_out;
    logic        [31:0] payload_out;
    logic        [6:0]  entries_now;
  } out_item_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_UPDATE,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] key;
  } cell_cmd_t;

  typedef struct packed {
    logic hit;
    logic below;
  } cell_flags_t;

endpackage

@@ rtl/core/mhpq_cell.sv @@
// One cell of the sorted entry chain: holds one key and payload.
`timescale 1ns / 1ps
module mhpq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7,
  parameter int PW  = 32
) (
  input  logic                  clk,
  input  mhpq_pkg::cell_cmd_t   cmd,
  input  logic [CW-1:0]         pos,
  input  logic [PW-1:0]         new_pay,
  input  logic signed [31:0]    prev_key,
  input  logic [PW-1:0]         prev_pay,
  input  logic signed [31:0]    next_key,
  input  logic [PW-1:0]         next_pay,
  output logic signed [31:0]    key_o,
  output logic [PW-1:0]         pay_o,
  output mhpq_pkg::cell_flags_t flags
);

  logic signed [31:0] key_r;
  logic signed [31:0] key_nxt;
  logic [PW-1:0]      pay_r;
  logic [PW-1:0]      pay_nxt;
  logic               sel;
  logic               after;

  assign sel   = (pos == CW'(IDX));
  assign after = (pos < CW'(IDX));

  always_comb begin
    key_nxt = key_r;
    pay_nxt = pay_r;
    case (cmd.op)
      mhpq_pkg::CELL_INSERT: begin
        if (sel) begin
          key_nxt = cmd.key;
          pay_nxt = new_pay;
        end else if (after) begin
          key_nxt = prev_key;
          pay_nxt = prev_pay;
        end
      end
      mhpq_pkg::CELL_UPDATE: begin
        if (sel) begin
          pay_nxt = new_pay;
        end
      end
      mhpq_pkg::CELL_SHIFT: begin
        key_nxt = next_key;
        pay_nxt = next_pay;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign key_o       = key_r;
  assign pay_o       = pay_r;
  assign flags.hit   = sel && (key_r == cmd.key);
  assign flags.below = sel && ($signed(cmd.key) > $signed(key_r));

endmodule

@@ rtl/core/max_heap_priority_queue.sv @@
// Entries are kept as a chain of cells sorted by key, largest first. For an insert, a
// pointer walks the chain one cell per cycle to find an equal key, whose payload is
// then updated, or the insertion place, where the cells behind it shift at once if
// the queue is not full. A delete of the maximum has every cell take its successor's
// entry at once. Results wait in an output register, and the block accepts the next
// item meanwhile.
`timescale 1ns / 1ps
`include "max_heap_priority_queue_macros.svh"
module max_heap_priority_queue #(
  parameter int HEAP_DEPTH   = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mhpq_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mhpq_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam logic REG_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEL
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       ptr_r;
  logic [6:0]          limit_r;
  logic                out_valid_r;
  mhpq_pkg::out_item_t out_data_r;
  mhpq_pkg::in_item_t  item_r;

  mhpq_pkg::cell_cmd_t   cell_cmd;
  mhpq_pkg::cell_flags_t flags_vec [HEAP_DEPTH];
  logic signed [31:0]    key_chain [HEAP_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_chain [HEAP_DEPTH];
  logic [HEAP_DEPTH-1:0] hit_vec;
  logic [HEAP_DEPTH-1:0] below_vec;
  logic [PAYLOAD_BITS-1:0] new_pay;

  logic                out_free;
  logic                at_end;
  logic                scan_stop;
  logic                full;
  logic                produce;
  logic                removing;
  logic [CW-1:0]       res_count;
  mhpq_pkg::out_item_t res;

  assign new_pay = PAYLOAD_BITS'(item_r.payload);

  for (genvar g = 0; g < HEAP_DEPTH; g++) begin : g_cell
    logic signed [31:0]      prev_key;
    logic [PAYLOAD_BITS-1:0] prev_pay;
    logic signed [31:0]      next_key;
    logic [PAYLOAD_BITS-1:0] next_pay;

    if (g == 0) begin : g_head
      assign prev_key = key_chain[g];
      assign prev_pay = pay_chain[g];
    end else begin : g_body
      assign prev_key = key_chain[g-1];
      assign prev_pay = pay_chain[g-1];
    end

    if (g == HEAP_DEPTH - 1) begin : g_tail
      assign next_key = key_chain[g];
      assign next_pay = pay_chain[g];
    end else begin : g_inner
      assign next_key = key_chain[g+1];
      assign next_pay = pay_chain[g+1];
    end

    mhpq_cell #(
      .IDX (g),
      .CW  (CW),
      .PW  (PAYLOAD_BITS)
    ) u_cell (
      .clk      (clk),
      .cmd      (cell_cmd),
      .pos      (ptr_r),
      .new_pay  (new_pay),
      .prev_key (prev_key),
      .prev_pay (prev_pay),
      .next_key (next_key),
      .next_pay (next_pay),
      .key_o    (key_chain[g]),
      .pay_o    (pay_chain[g]),
      .flags    (flags_vec[g])
    );

    assign hit_vec[g]   = flags_vec[g].hit;
    assign below_vec[g] = flags_vec[g].below;
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign at_end    = (ptr_r == count_r);
  assign scan_stop = at_end || (|hit_vec) || (|below_vec);
  assign full      = (32'(count_r) >= 32'(limit_r)) || (32'(count_r) >= HEAP_DEPTH);

  always_comb begin
    cell_cmd.op  = mhpq_pkg::CELL_HOLD;
    cell_cmd.key = item_r.key;
    produce      = 1'b0;
    res_count    = count_r;
    res          = '0;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_SCAN: begin
        if (scan_stop && out_free) begin
          produce = 1'b1;
          if (!at_end && (|hit_vec)) begin
            cell_cmd.op = mhpq_pkg::CELL_UPDATE;
            res.status  = mhpq_pkg::STATUS_UPDATED;
          end else if (full) begin
            res.status  = mhpq_pkg::STATUS_FULL;
          end else begin
            cell_cmd.op = mhpq_pkg::CELL_INSERT;
            res.status  = mhpq_pkg::STATUS_INSERTED;
            res_count   = count_r + 1'b1;
          end
        end
      end
      ST_DEL: begin
        if (out_free) begin
          produce = 1'b1;
          if (count_r == '0) begin
            res.status = mhpq_pkg::STATUS_EMPTY;
          end else begin
            cell_cmd.op     = mhpq_pkg::CELL_SHIFT;
            res.status      = mhpq_pkg::STATUS_REMOVED;
            res.key_out     = key_chain[0];
            res.payload_out = 32'(pay_chain[0]);
            res_count       = count_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res.entries_now = 7'(res_count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      limit_r     <= 7'd64;
      out_valid_r <= 1'b0;
    end else begin
      if (psel && penable && pwrite && (paddr[2] == REG_LIMIT)) begin
        limit_r <= pwdata[6:0];
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            ptr_r   <= '0;
            state_r <= (in_data.action == mhpq_pkg::ACT_DELETE) ? ST_DEL : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (produce) begin
            count_r <= res_count;
            state_r <= ST_IDLE;
          end else if (!scan_stop) begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
        ST_DEL: begin
          if (produce) begin
            count_r <= res_count;
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (produce) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_LIMIT) ? 32'(limit_r) : 32'd0;
  assign removing  = produce && (res.status == mhpq_pkg::STATUS_REMOVED);

  `MHPQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, 32'(count_r) <= HEAP_DEPTH)
  `MHPQ_ASSERT_SAME(a_insert_room, clk, rst_n, cell_cmd.op == mhpq_pkg::CELL_INSERT, !full)
  `MHPQ_ASSERT_SAME(a_ptr_bound, clk, rst_n, state_r == ST_SCAN, ptr_r <= count_r)
  `MHPQ_ASSERT_NEXT(a_remove_count, clk, rst_n, removing, (count_r + 1'b1) == $past(count_r))

endmodule

@@ sim/tb_max_heap_priority_queue.sv @@
// Self-checking testbench for the max-heap priority queue with a heap predictor.
`timescale 1ns / 1ps
module tb_max_heap_priority_queue;

  localparam int HEAP_DEPTH = 64;
  localparam int STUCK_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS = 40;
  localparam logic [2:0] CAP_LIMIT_ADDR = 3'd0;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] KEY_MIN = 32'sh80000000;

  class heap_scoreboard;
    logic signed [31:0] heap_key [1:HEAP_DEPTH];
    logic [31:0] heap_pay [1:HEAP_DEPTH];
    int count;
    logic [6:0] limit;
    mhpq_pkg::out_item_t expected_q[$];
    int errors;

    function new();
      count = 0;
      limit = 7'd64;
      errors = 0;
    endfunction

    task report(input string msg);
      if (errors < MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    function void note_item(input mhpq_pkg::in_item_t it);
      mhpq_pkg::out_item_t r;
      int idx, par, lft, rgt, big, cap;
      logic signed [31:0] k, last_key;
      logic [31:0] last_pay;
      bit hit;
      r = '0;
      k = it.key;
      if (it.action == mhpq_pkg::ACT_DELETE) begin
        if (count == 0) begin
          r.status = mhpq_pkg::STATUS_EMPTY;
        end else begin
          r.status = mhpq_pkg::STATUS_REMOVED;
          r.key_out = heap_key[1];
          r.payload_out = heap_pay[1];
          last_key = heap_key[count];
          last_pay = heap_pay[count];
          count--;
          idx = 1;
          while (2 * idx <= count) begin
            lft = 2 * idx;
            rgt = lft + 1;
            big = (rgt <= count && heap_key[lft] < heap_key[rgt]) ? rgt : lft;
            if (last_key > heap_key[big]) break;
            heap_key[idx] = heap_key[big];
            heap_pay[idx] = heap_pay[big];
            idx = big;
          end
          heap_key[idx] = last_key;
          heap_pay[idx] = last_pay;
        end
      end else begin
        hit = 1'b0;
        for (int i = 1; i <= count; i++) begin
          if (!hit && heap_key[i] == k) begin
            heap_pay[i] = it.payload;
            hit = 1'b1;
          end
        end
        cap = (limit > HEAP_DEPTH) ? HEAP_DEPTH : int'(limit);
        if (hit) begin
          r.status = mhpq_pkg::STATUS_UPDATED;
        end else if (count >= cap) begin
          r.status = mhpq_pkg::STATUS_FULL;
        end else begin
          r.status = mhpq_pkg::STATUS_INSERTED;
          count++;
          idx = count;
          while (idx > 1) begin
            par = idx >> 1;
            if (heap_key[par] > k) break;
            heap_key[idx] = heap_key[par];
            heap_pay[idx] = heap_pay[par];
            idx = par;
          end
          heap_key[idx] = k;
          heap_pay[idx] = it.payload;
        end
      end
      r.entries_now = count[6:0];
      expected_q.push_back(r);
    endfunction

    task check_result(input mhpq_pkg::out_item_t got);
      mhpq_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result item status=%0d", got.status));
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.key_out !== want.key_out)
          report($sformatf("key_out got %0d want %0d", got.key_out, want.key_out));
        if (got.payload_out !== want.payload_out)
          report($sformatf("payload_out got %h want %h", got.payload_out, want.payload_out));
        if (got.entries_now !== want.entries_now)
          report($sformatf("entries_now got %0d want %0d", got.entries_now, want.entries_now));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mhpq_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mhpq_pkg::out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  heap_scoreboard sb = new();
  int idle_pct = 20;
  bit hold_req = 1'b0;
  int stuck = 0;

  max_heap_priority_queue u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("max_heap_priority_queue test failed");
        $finish;
      end
    end
  end

  initial begin
    int stall_left;
    int hold_left;
    bit hold_taken;
    stall_left = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_pct > 0 && $urandom_range(0, 199) < idle_pct) begin
        stall_left = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic mhpq_pkg::in_item_t make_item(input logic act,
                                                   input logic signed [31:0] k,
                                                   input logic [31:0] p);
    mhpq_pkg::in_item_t it;
    it.action = act;
    it.key = k;
    it.payload = p;
    return it;
  endfunction

  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] k;
    case ($urandom_range(0, 9)) inside
      [0:3]: k = $signed($urandom_range(0, 15)) - 8;
      4: begin
        case ($urandom_range(0, 3))
          0: k = KEY_MAX;
          1: k = KEY_MIN;
          2: k = 32'sd0;
          default: k = -32'sd1;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic mhpq_pkg::in_item_t rand_item(input int del_pct);
    logic act;
    act = ($urandom_range(0, 99) < del_pct) ? mhpq_pkg::ACT_DELETE : mhpq_pkg::ACT_INSERT;
    return make_item(act, pick_key(), $urandom);
  endfunction

  task automatic send_item(input mhpq_pkg::in_item_t it);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_limit(input logic [6:0] lim);
    logic [31:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAP_LIMIT_ADDR;
    pwdata <= {25'd0, lim};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.limit = lim;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== {25'd0, lim})
      sb.report($sformatf("capacity_limit read %h want %h", readback, lim));
  endtask

  task automatic run_phase(input logic [6:0] lim, input int n, input int del_pct,
                           input int idle);
    drain();
    set_limit(lim);
    idle_pct = idle;
    for (int i = 0; i < n; i++) send_item(rand_item(del_pct));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty heap, key and payload extremes, an update, then removal in key order.
    send_item(make_item(mhpq_pkg::ACT_DELETE, KEY_MAX, 32'hFFFF_FFFF));
    send_item(make_item(mhpq_pkg::ACT_INSERT, KEY_MAX, 32'hFFFF_FFFF));
    send_item(make_item(mhpq_pkg::ACT_INSERT, KEY_MIN, 32'h0000_0000));
    send_item(make_item(mhpq_pkg::ACT_INSERT, 32'sd0, 32'hA5A5_5A5A));
    send_item(make_item(mhpq_pkg::ACT_INSERT, -32'sd1, 32'h5A5A_A5A5));
    send_item(make_item(mhpq_pkg::ACT_INSERT, KEY_MAX, 32'h1234_5678));
    repeat (5) send_item(make_item(mhpq_pkg::ACT_DELETE, 32'sd0, 32'h0));

    // A small limit, a limit lowered below the count, and a zero limit.
    drain();
    set_limit(7'd2);
    send_item(make_item(mhpq_pkg::ACT_INSERT, 32'sd5, 32'h0000_0005));
    send_item(make_item(mhpq_pkg::ACT_INSERT, 32'sd7, 32'h0000_0007));
    send_item(make_item(mhpq_pkg::ACT_INSERT, 32'sd9, 32'h0000_0009));
    send_item(make_item(mhpq_pkg::ACT_INSERT, 32'sd7, 32'h0000_0077));
    drain();
    set_limit(7'd1);
    send_item(make_item(mhpq_pkg::ACT_INSERT, 32'sd3, 32'h0000_0003));
    send_item(make_item(mhpq_pkg::ACT_INSERT, 32'sd5, 32'h0000_0055));
    drain();
    set_limit(7'd0);
    send_item(make_item(mhpq_pkg::ACT_INSERT, 32'sd11, 32'h0000_0011));
    send_item(make_item(mhpq_pkg::ACT_INSERT, 32'sd5, 32'hFFFF_0000));
    repeat (3) send_item(make_item(mhpq_pkg::ACT_DELETE, 32'sd0, 32'h0));

    // The receiver holds off for a long stretch while items keep coming.
    drain();
    set_limit(7'd64);
    idle_pct = 20;
    hold_req = 1'b1;
    for (int i = 0; i < 200; i++) send_item(rand_item(35));

    run_phase(7'd127, 150, 20, 20);
    run_phase(7'd5, 100, 40, 25);
    run_phase(7'd1, 60, 40, 20);
    run_phase(7'($urandom_range(1, 64)), 200, 50, 15);
    run_phase(7'd0, 30, 50, 20);
    run_phase(7'd64, 150, 45, 0);

    drain();
    repeat (HEAP_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("max_heap_priority_queue test passed");
    end else begin
      $display("max_heap_priority_queue test failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_cell.sv
rtl/core/max_heap_priority_queue.sv
sim/tb_max_heap_priority_queue.sv
